>>> rtl/rgbw_led_wire_bit_encoder_top_assert.svh
// assertion macros shared by the encoder top level
`ifndef RGBW_LED_WIRE_BIT_ENCODER_TOP_ASSERT_SVH
`define RGBW_LED_WIRE_BIT_ENCODER_TOP_ASSERT_SVH

// condition must hold at every edge outside reset
`define RGBWENC_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("rgbwenc assertion failed");

// consequent must hold in the cycle after the antecedent
`define RGBWENC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rgbwenc assertion failed");

`endif

>>> rtl/rgbwenc_pkg.sv
`default_nettype none
package rgbwenc_pkg;

   localparam int CHAN_W     = 8;
   localparam int SLOTS_RGBW = 4 * CHAN_W;
   localparam int SLOTS_RGB  = 3 * CHAN_W;
   localparam int CNT_W      = $clog2(SLOTS_RGBW);
   localparam int CSR_AW     = 3;
   localparam int CSR_DW     = 32;

   localparam logic [CHAN_W-1:0] LOW_DUTY_RST  = 8'd19;
   localparam logic [CHAN_W-1:0] HIGH_DUTY_RST = 8'd38;

   // register index, taken from the word address
   localparam logic [0:0] REG_LOW_DUTY  = 1'b0;
   localparam logic [0:0] REG_HIGH_DUTY = 1'b1;

   typedef struct packed {
      logic load;
      logic shift;
   } ctl_cmd_type;

   typedef struct packed {
      logic last;
   } dp_sts_type;

endpackage
`default_nettype wire

>>> rtl/rgbwenc_csr.sv
`default_nettype none
module rgbwenc_csr
   import rgbwenc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic      [CSR_DW-1:0] csr_prdata,
   output logic                   csr_pready,
   output logic      [CHAN_W-1:0] low_duty,
   output logic      [CHAN_W-1:0] high_duty
);

   logic [CHAN_W-1:0] low_duty_ff, low_duty_in;
   logic [CHAN_W-1:0] high_duty_ff, high_duty_in;
   logic [0:0]        reg_idx;
   logic              wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[2:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      low_duty_in  = low_duty_ff;
      high_duty_in = high_duty_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_LOW_DUTY:  low_duty_in  = csr_pwdata[CHAN_W-1:0];
            REG_HIGH_DUTY: high_duty_in = csr_pwdata[CHAN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_LOW_DUTY:  csr_prdata = {{(CSR_DW-CHAN_W){1'b0}}, low_duty_ff};
         REG_HIGH_DUTY: csr_prdata = {{(CSR_DW-CHAN_W){1'b0}}, high_duty_ff};
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_duty_ff  <= LOW_DUTY_RST;
         high_duty_ff <= HIGH_DUTY_RST;
      end else begin
         low_duty_ff  <= low_duty_in;
         high_duty_ff <= high_duty_in;
      end
   end

   assign low_duty  = low_duty_ff;
   assign high_duty = high_duty_ff;

endmodule
`default_nettype wire

>>> rtl/rgbwenc_dp.sv
`default_nettype none
module rgbwenc_dp
   import rgbwenc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic [CHAN_W-1:0] red,
   input  wire logic [CHAN_W-1:0] green,
   input  wire logic [CHAN_W-1:0] blue,
   input  wire logic              is_rgbw,
   input  wire logic [CHAN_W-1:0] low_duty,
   input  wire logic [CHAN_W-1:0] high_duty,
   input  wire ctl_cmd_type       cmd,
   output dp_sts_type             sts,
   output logic      [CHAN_W-1:0] duty,
   output logic                   last_of_led
);

   logic [SLOTS_RGBW-1:0] shift_ff, shift_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [CHAN_W-1:0]     min_rg, white;
   logic [SLOTS_RGBW-1:0] word;

   // in RGBW mode, white is the smallest colour, taken out of each channel
   always_comb begin
      min_rg = (red < green) ? red : green;
      white  = (blue < min_rg) ? blue : min_rg;
      if (is_rgbw) begin
         word = {green - white, red - white, blue - white, white};
      end else begin
         word = {green, red, blue, {CHAN_W{1'b0}}};
      end
   end

   always_comb begin
      shift_in = shift_ff;
      cnt_in   = cnt_ff;
      if (cmd.load) begin
         shift_in = word;
         cnt_in   = is_rgbw ? CNT_W'(SLOTS_RGBW - 1) : CNT_W'(SLOTS_RGB - 1);
      end else if (cmd.shift) begin
         shift_in = {shift_ff[SLOTS_RGBW-2:0], 1'b0};
         cnt_in   = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      cnt_ff   <= cnt_in;
   end

   assign last_of_led = (cnt_ff == '0);
   assign sts.last    = last_of_led;
   assign duty        = shift_ff[SLOTS_RGBW-1] ? high_duty : low_duty;

endmodule
`default_nettype wire

>>> rtl/rgbwenc_ctrl.sv
`default_nettype none
module rgbwenc_ctrl
   import rgbwenc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire dp_sts_type  sts,
   output ctl_cmd_type      cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   state_type state_ff;
   logic      ready_ff;
   logic      valid_ff;

   assign cmd.load   = req_tvalid & ready_ff;
   assign cmd.shift  = valid_ff & rsp_tready;
   assign req_tready = ready_ff;
   assign rsp_tvalid = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (cmd.load) begin
                  state_ff <= ST_EMIT;
                  ready_ff <= 1'b0;
                  valid_ff <= 1'b1;
               end else begin
                  ready_ff <= 1'b1;
               end
            end
            ST_EMIT: begin
               // leave after the final slot of the led is taken
               if (cmd.shift && sts.last) begin
                  state_ff <= ST_IDLE;
                  ready_ff <= 1'b1;
                  valid_ff <= 1'b0;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               ready_ff <= 1'b0;
               valid_ff <= 1'b0;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

>>> rtl/rgbw_led_wire_bit_encoder_top.sv
// Serializes one LED colour into PWM duty values, one per wire bit, in the
// order green, red, blue, then white for RGBW chips, MSB first per channel;
// a one bit sends high_duty and a zero bit low_duty, and tlast marks the
// final slot, the 24th (RGB) or 32nd (RGBW). An accepted LED is loaded into
// the shift register, which then gives one duty slot per cycle while the
// output is ready and holds on a stall. The next LED is taken the cycle
// after the last slot leaves.
`default_nettype none
module rgbw_led_wire_bit_encoder_top
   import rgbwenc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [23:0]       req_tdata,   // red, green, blue
   input  wire logic [0:0]        req_tuser,   // is_rgbw
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic      [7:0]        rsp_tdata,   // duty
   output logic                   rsp_tlast,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic      [CSR_DW-1:0] csr_prdata,
   output logic                   csr_pready
);

`include "rgbw_led_wire_bit_encoder_top_assert.svh"

   logic [CHAN_W-1:0] low_duty;
   logic [CHAN_W-1:0] high_duty;
   ctl_cmd_type       cmd;
   dp_sts_type        sts;

   rgbwenc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .low_duty    (low_duty),
      .high_duty   (high_duty)
   );

   rgbwenc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   rgbwenc_dp u_dp (
      .clock       (clock),
      .red         (req_tdata[7:0]),
      .green       (req_tdata[15:8]),
      .blue        (req_tdata[23:16]),
      .is_rgbw     (req_tuser[0]),
      .low_duty    (low_duty),
      .high_duty   (high_duty),
      .cmd         (cmd),
      .sts         (sts),
      .duty        (rsp_tdata),
      .last_of_led (rsp_tlast)
   );

   // input and output sides are never open at once
   `RGBWENC_ASSERT_ALWAYS(a_one_side, clock, reset, !(req_tready && rsp_tvalid))
   // an accepted item starts emitting on the next cycle
   `RGBWENC_ASSERT_NEXT(a_start, clock, reset, req_tvalid && req_tready,
                        rsp_tvalid && !rsp_tlast)
   // after the final slot the output goes quiet and input reopens
   `RGBWENC_ASSERT_NEXT(a_finish, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast,
                        !rsp_tvalid && req_tready)

endmodule
`default_nettype wire

>>> dv/testbench.sv
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import rgbwenc_pkg::*;

   typedef struct packed {
      logic [CHAN_W-1:0] duty;
      logic              last;
   } duty_slot_type;

   // predicts the duty stream of each led and checks what comes out
   class duty_scoreboard;
      logic [CHAN_W-1:0] low_duty;
      logic [CHAN_W-1:0] high_duty;
      duty_slot_type     expected_slots[$];
      int                mismatches;

      function new();
         low_duty   = LOW_DUTY_RST;
         high_duty  = HIGH_DUTY_RST;
         mismatches = 0;
      endfunction

      task report(input string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         mismatches++;
      endtask

      function void note_led(input logic [CHAN_W-1:0] red, input logic [CHAN_W-1:0] green,
                             input logic [CHAN_W-1:0] blue, input logic rgbw);
         logic [CHAN_W-1:0] white;
         logic [CHAN_W-1:0] chans[4];
         int                nchan;
         duty_slot_type     s;
         white = '0;
         if (rgbw) begin
            white = (red < green) ? red : green;
            if (blue < white) white = blue;
         end
         chans[0] = green - white;
         chans[1] = red - white;
         chans[2] = blue - white;
         chans[3] = white;
         nchan = rgbw ? 4 : 3;
         for (int c = 0; c < nchan; c++) begin
            for (int b = CHAN_W - 1; b >= 0; b--) begin
               s.duty = chans[c][b] ? high_duty : low_duty;
               s.last = (c == nchan - 1) && (b == 0);
               expected_slots.push_back(s);
            end
         end
      endfunction

      task check_slot(input logic [CHAN_W-1:0] duty, input logic last);
         duty_slot_type want;
         if (expected_slots.size() == 0) begin
            report($sformatf("duty %0d last %0b with nothing expected", duty, last));
         end else begin
            want = expected_slots.pop_front();
            if (duty !== want.duty)
               report($sformatf("duty got %0d want %0d", duty, want.duty));
            if (last !== want.last)
               report($sformatf("last got %0b want %0b", last, want.last));
         end
      endtask

      function int pending();
         return expected_slots.size();
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [23:0]       req_tdata = '0;   // red, green, blue
   logic [0:0]        req_tuser = '0;   // is_rgbw
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [7:0]        rsp_tdata;        // duty
   logic              rsp_tlast;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   logic           hold_rsp = 1'b0;
   int             send_idle_pct = 0;
   int             recv_idle_pct = 0;
   duty_scoreboard sb;

   rgbw_led_wire_bit_encoder_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (hold_rsp) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         sb.note_led(req_tdata[7:0], req_tdata[15:8], req_tdata[23:16], req_tuser[0]);
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_slot(rsp_tdata, rsp_tlast);
   end

   task automatic csr_access(input logic write, input logic [0:0] idx,
                             input logic [CSR_DW-1:0] wdata, output logic [CSR_DW-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_duty(input logic [0:0] idx, input logic [CHAN_W-1:0] value);
      logic [CSR_DW-1:0] word;
      logic [CSR_DW-1:0] rdata;
      // junk in the upper bits must be dropped
      word = $urandom;
      word[CHAN_W-1:0] = value;
      csr_access(1'b1, idx, word, rdata);
      if (idx == REG_LOW_DUTY) sb.low_duty = value;
      else sb.high_duty = value;
      csr_access(1'b0, idx, '0, rdata);
      if (rdata[CHAN_W-1:0] !== value)
         sb.report($sformatf("register %0d reads %0d want %0d", idx, rdata[CHAN_W-1:0], value));
   endtask

   task automatic send_led(input logic [7:0] red, input logic [7:0] green,
                           input logic [7:0] blue, input logic rgbw);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {blue, green, red};
      req_tuser  <= rgbw;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] rand_level();
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'hff;
         2: return 8'h01 << $urandom_range(7);
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic send_random(input int count, input int pause_at);
      for (int i = 0; i < count; i++) begin
         if (i == pause_at) wait_drained();
         send_led(rand_level(), rand_level(), rand_level(), 1'($urandom_range(1)));
      end
   endtask

   initial begin
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset duties, no idling
      send_led(8'h00, 8'h00, 8'h00, 1'b0);
      send_led(8'hff, 8'hff, 8'hff, 1'b0);
      send_led(8'h00, 8'h00, 8'h00, 1'b1);
      send_led(8'hff, 8'hff, 8'hff, 1'b1);
      send_led(8'h80, 8'h01, 8'haa, 1'b0);
      send_led(8'h55, 8'haa, 8'h0f, 1'b0);
      send_led(8'hff, 8'h00, 8'hff, 1'b1);
      send_led(8'h10, 8'h80, 8'hc0, 1'b1);   // red is the smallest
      send_led(8'hc0, 8'h10, 8'h80, 1'b1);   // green is the smallest
      send_led(8'h80, 8'hc0, 8'h10, 1'b1);   // blue is the smallest
      send_led(8'h7f, 8'h7f, 8'h7f, 1'b1);
      send_led(8'h01, 8'h02, 8'h03, 1'b1);
      send_led(8'hfe, 8'hff, 8'hfd, 1'b1);
      send_led(8'h81, 8'h42, 8'h24, 1'b0);
      send_led(8'h00, 8'hff, 8'h00, 1'b0);
      send_led(8'h00, 8'h00, 8'hff, 1'b1);
      send_led(8'hff, 8'h00, 8'h00, 1'b0);
      send_led(8'h33, 8'hcc, 8'h99, 1'b1);
      wait_drained();

      set_duty(REG_LOW_DUTY, 8'h00);
      set_duty(REG_HIGH_DUTY, 8'hff);
      send_idle_pct = 21;
      recv_idle_pct = 74;
      send_random(140, 70);
      wait_drained();

      set_duty(REG_LOW_DUTY, 8'hff);
      set_duty(REG_HIGH_DUTY, 8'h00);
      send_idle_pct = 74;
      recv_idle_pct = 21;
      send_random(140, -1);
      wait_drained();

      // both duties equal
      set_duty(REG_LOW_DUTY, 8'd90);
      set_duty(REG_HIGH_DUTY, 8'd90);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_led(8'hff, 8'h00, 8'haa, 1'b0);
      send_random(30, -1);
      wait_drained();

      set_duty(REG_LOW_DUTY, CHAN_W'($urandom_range(255)));
      set_duty(REG_HIGH_DUTY, CHAN_W'($urandom_range(255)));
      fork
         begin
            hold_rsp <= 1'b1;
            repeat (400) @(posedge clock);
            hold_rsp <= 1'b0;
         end
         send_random(100, -1);
      join
      wait_drained();

      repeat (40) @(posedge clock);
      if (sb.pending() != 0)
         sb.report($sformatf("%0d duty slots never arrived", sb.pending()));
      if (sb.mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end
endmodule
`default_nettype wire

>>> files.f
+incdir+rtl
rtl/rgbwenc_pkg.sv
rtl/rgbwenc_csr.sv
rtl/rgbwenc_dp.sv
rtl/rgbwenc_ctrl.sv
rtl/rgbw_led_wire_bit_encoder_top.sv
dv/testbench.sv
